>>> rtl/mdq_pkg.sv
// Shared types and constants for the motion debounce qualifier.
// No dependencies; imported by mdq_motion_detect and motion_debounce_qualifier.
package mdq_pkg;

    // Field and register widths
    localparam int SAMPLE_WIDTH_DEF = 17;
    localparam int Z_THR_W          = 16;
    localparam int CHG_THR_W        = 17;
    localparam int DBT_W            = 8;
    localparam int COUNT_W          = DBT_W + 1;
    localparam int CFG_DATA_W       = 17;
    localparam int CFG_INDEX_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_Z_THRESHOLD        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_THRESHOLD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_THRESHOLD = 2'd2;

    // Register reset values (0.20 m/s^2, 0.05 m/s^2 in 1/256 units; 30 samples)
    localparam logic [Z_THR_W-1:0]   Z_THRESHOLD_RST        = 16'd51;
    localparam logic [CHG_THR_W-1:0] CHANGE_THRESHOLD_RST   = 17'd13;
    localparam logic [DBT_W-1:0]     DEBOUNCE_THRESHOLD_RST = 8'd30;

    // Per-sample classification handed from the detector to the counter logic
    typedef struct packed {
        logic motion;
        logic fault;
    } detect_t;

endpackage

>>> rtl/mdq_motion_detect.sv
// Motion classifier: magnitude compares of one sample against thresholds
// and the previous sample. Depends on mdq_pkg.
module mdq_motion_detect #(
    parameter int SAMPLE_WIDTH = mdq_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic signed [SAMPLE_WIDTH-1:0]     accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]     accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]     accel_z,
    input  logic signed [SAMPLE_WIDTH-1:0]     previous_x,
    input  logic signed [SAMPLE_WIDTH-1:0]     previous_y,
    input  logic signed [SAMPLE_WIDTH-1:0]     previous_z,
    input  logic [mdq_pkg::Z_THR_W-1:0]        z_threshold,
    input  logic [mdq_pkg::CHG_THR_W-1:0]      change_threshold,
    output mdq_pkg::detect_t                   detect
);
    import mdq_pkg::*;

    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > CHG_THR_W) ? DIFF_W : CHG_THR_W;

    // Absolute difference of two signed samples, one guard bit wide
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic [SAMPLE_WIDTH-1:0] a,
        input logic [SAMPLE_WIDTH-1:0] b
    );
        logic [DIFF_W-1:0] d;
        d = {a[SAMPLE_WIDTH-1], a} - {b[SAMPLE_WIDTH-1], b};
        return d[DIFF_W-1] ? (~d + 1'b1) : d;
    endfunction

    logic [SAMPLE_WIDTH-1:0] z_mag;
    logic [DIFF_W-1:0]       dx_mag;
    logic [DIFF_W-1:0]       dy_mag;
    logic [DIFF_W-1:0]       dz_mag;
    logic                    z_hit;
    logic                    chg_hit;
    logic                    all_zero;

    assign z_mag  = accel_z[SAMPLE_WIDTH-1] ? (~accel_z + 1'b1) : accel_z;
    assign dx_mag = abs_diff(accel_x, previous_x);
    assign dy_mag = abs_diff(accel_y, previous_y);
    assign dz_mag = abs_diff(accel_z, previous_z);

    assign z_hit   = CMP_W'(z_mag) >= CMP_W'(z_threshold);
    assign chg_hit = (CMP_W'(dx_mag) >= CMP_W'(change_threshold))
                  || (CMP_W'(dy_mag) >= CMP_W'(change_threshold))
                  || (CMP_W'(dz_mag) >= CMP_W'(change_threshold));

    assign all_zero = (accel_x == '0) && (accel_y == '0) && (accel_z == '0);

    // An all-zero sample is a sensor fault and never counts as motion
    assign detect.fault  = all_zero;
    assign detect.motion = !all_zero && (z_hit || chg_hit);

endmodule

>>> rtl/motion_debounce_qualifier.sv
// Top level of the motion debounce qualifier: config registers, debounce
// counter, previous-sample state and result register. Depends on mdq_pkg, mdq_motion_detect.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one signed three-axis sample per
//   transaction. Result channel (m_valid/m_ready) returns exactly one result per
//   sample: active (counter before the update was at or above the debounce
//   threshold), motion_seen, and sensor_fault (all three axes zero; state held).
//   Latency: the result is valid on the cycle after the sample is accepted.
//   Throughput: one sample per cycle while the receiver keeps m_ready high; the
//   classifier, counter update and result register form a single registered stage.
//   Stall: when the receiver holds m_ready low, the result register holds its
//   transaction and s_ready drops; a new sample is taken in the same cycle the
//   pending result is taken.
//   Reset (aresetn low, synchronous): counter and previous samples clear to
//   zero, thresholds return to 51, 13 and 30, and the result register empties.
//   Configuration: cfg_we writes cfg_wdata to the register at cfg_index
//   (0 z threshold, 1 change threshold, 2 debounce threshold);
//   write only while no sample is in flight. Other indexes are ignored.
module motion_debounce_qualifier #(
    parameter int SAMPLE_WIDTH = mdq_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_we,
    input  logic [mdq_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mdq_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // sample input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_accel_z,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_active,
    output logic                                 m_motion_seen,
    output logic                                 m_sensor_fault
);
    import mdq_pkg::*;

    logic [Z_THR_W-1:0]             z_thr_reg;
    logic [CHG_THR_W-1:0]           chg_thr_reg;
    logic [DBT_W-1:0]               dbt_reg;
    logic [COUNT_W-1:0]             count_reg;
    logic [COUNT_W-1:0]             count_next;
    logic signed [SAMPLE_WIDTH-1:0] prev_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_y_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_z_reg;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic                           active_reg;
    logic                           motion_reg;
    logic                           fault_reg;
    logic                           s_fire;
    logic                           active_now;
    detect_t                        det;

    mdq_motion_detect #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_detect (
        .accel_x          (s_accel_x),
        .accel_y          (s_accel_y),
        .accel_z          (s_accel_z),
        .previous_x       (prev_x_reg),
        .previous_y       (prev_y_reg),
        .previous_z       (prev_z_reg),
        .z_threshold      (z_thr_reg),
        .change_threshold (chg_thr_reg),
        .detect           (det)
    );

    assign s_ready    = !m_valid_reg || m_ready;
    assign s_fire     = s_valid && s_ready;
    assign active_now = count_reg >= {1'b0, dbt_reg};

    // Integrating counter: rise on motion up to threshold + 1, fall by one to a floor of zero
    always_comb begin
        count_next = count_reg;
        if (s_fire && !det.fault) begin
            if (det.motion) begin
                if (count_reg <= {1'b0, dbt_reg}) begin
                    count_next = count_reg + 1'b1;
                end
            end else if (count_reg != '0) begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_thr_reg   <= Z_THRESHOLD_RST;
            chg_thr_reg <= CHANGE_THRESHOLD_RST;
            dbt_reg     <= DEBOUNCE_THRESHOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_Z_THRESHOLD:        z_thr_reg   <= cfg_wdata[Z_THR_W-1:0];
                REG_CHANGE_THRESHOLD:   chg_thr_reg <= cfg_wdata[CHG_THR_W-1:0];
                REG_DEBOUNCE_THRESHOLD: dbt_reg     <= cfg_wdata[DBT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            prev_z_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            // hold the previous sample across a faulted transaction
            if (s_fire && !det.fault) begin
                prev_x_reg <= s_accel_x;
                prev_y_reg <= s_accel_y;
                prev_z_reg <= s_accel_z;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            active_reg <= active_now;
            motion_reg <= det.motion;
            fault_reg  <= det.fault;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_active       = active_reg;
    assign m_motion_seen  = motion_reg;
    assign m_sensor_fault = fault_reg;

`ifndef SYNTHESIS
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1)
         || (count_reg == $past(count_reg) - 1'b1))
        else $error("debounce counter moved by more than one");

    a_fault_no_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sensor_fault |-> !m_motion_seen)
        else $error("faulted result reports motion");

    a_fault_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && det.fault |=> $stable(count_reg) && $stable(prev_x_reg)
            && $stable(prev_y_reg) && $stable(prev_z_reg))
        else $error("state changed on a faulted sample");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid && (m_active == $past(active_now)))
        else $error("result register missed an accepted sample");
`endif

endmodule
